[rtl/mhs_pkg.sv]
// mhs_pkg: shared types and constants of the murmurhash2 stream hasher
// no dependencies; imported by every module under rtl
`timescale 1ns / 1ps

package mhs_pkg;

   localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
   localparam int          MIX_SHIFT   = 24;
   localparam int          FIN_SHIFT_A = 13;
   localparam int          FIN_SHIFT_B = 15;
   localparam logic [31:0] SEED_RESET  = 32'd97;
   localparam logic [2:0]  FULL_BYTES  = 3'd4;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // one classified item on its way from the front to the engine
   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  valid_bytes;   // saturated to four
      logic        first_word;
      logic        last_word;
      logic [15:0] message_length; // saturated to the maximum length
   } item_type;

endpackage

[rtl/mhs_front.sv]
// mhs_front: takes items from the request stream, drops items outside a message
// depends on mhs_pkg
`timescale 1ns / 1ps

module mhs_front #(
   parameter int MAX_MESSAGE_BYTES = 65535
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [55:0]       req_tdata,  // data_word, valid_bytes, message_length, zero pad
   input  logic              req_tlast,
   input  logic              req_tuser,  // first_word
   input  logic              q_full,
   output logic              q_push,
   output mhs_pkg::item_type q_item
);
   import mhs_pkg::*;

   localparam logic [31:0] MaxBytes = 32'(MAX_MESSAGE_BYTES);

   logic        in_msg_ff;
   logic        in_msg_in;
   logic        accept;
   logic        keep;
   logic [2:0]  nbytes;
   logic [15:0] len;

   assign nbytes = req_tdata[34:32];
   assign len    = req_tdata[50:35];

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   // an item that neither opens a message nor belongs to one is dropped
   assign keep       = req_tuser || in_msg_ff;
   assign q_push     = accept && keep;

   always_comb begin
      q_item.data_word      = req_tdata[31:0];
      q_item.valid_bytes    = (nbytes > FULL_BYTES) ? FULL_BYTES : nbytes;
      q_item.first_word     = req_tuser;
      q_item.last_word      = req_tlast;
      q_item.message_length = ({16'd0, len} > MaxBytes) ? MaxBytes[15:0] : len;
   end

   assign in_msg_in = q_push ? !req_tlast : in_msg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_msg_ff <= 1'b0;
      end else begin
         in_msg_ff <= in_msg_in;
      end
   end

endmodule

[rtl/mhs_fifo.sv]
// mhs_fifo: short queue of classified items between front and engine
// depends on mhs_pkg
`timescale 1ns / 1ps

module mhs_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mhs_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output mhs_pkg::item_type pop_item
);
   import mhs_pkg::*;

   item_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff;
   logic [QCNT_W-1:0]  count_in;
   logic               do_push;
   logic               do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_item  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[rtl/mhs_engine.sv]
// mhs_engine: sequencer around one shared multiplier that mixes and finalizes the hash
// depends on mhs_pkg
`timescale 1ns / 1ps

module mhs_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic [31:0]       seed,
   input  logic              q_valid,
   input  mhs_pkg::item_type q_item,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata   // result hash
);
   import mhs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_K1,
      ST_K2,
      ST_HMIX,
      ST_TAIL,
      ST_FIN,
      ST_EMIT
   } state_type;

   state_type   state_ff;
   state_type   state_in;
   item_type    item_ff;
   item_type    item_in;
   logic [31:0] hash_ff;
   logic [31:0] hash_in;
   logic [31:0] k_ff;
   logic [31:0] k_in;
   logic        out_valid_ff;
   logic        out_valid_in;
   logic [31:0] out_data_ff;
   logic [31:0] out_data_in;
   logic [31:0] mul_a;
   logic [31:0] product;
   logic [31:0] tail_mask;
   logic [31:0] start_hash;
   logic        out_free;

   assign product  = mul_a * MIX_MUL;
   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      case (item_ff.valid_bytes)
         3'd1:    tail_mask = 32'h0000_00ff;
         3'd2:    tail_mask = 32'h0000_ffff;
         default: tail_mask = 32'h00ff_ffff;
      endcase
   end

   assign start_hash = q_item.first_word ? (seed ^ {16'd0, q_item.message_length}) : hash_ff;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      hash_in      = hash_ff;
      k_in         = k_ff;
      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      q_pop        = 1'b0;
      mul_a        = hash_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               item_in = q_item;
               hash_in = start_hash;
               if (q_item.valid_bytes == FULL_BYTES) begin
                  state_in = ST_K1;
               end else if (q_item.valid_bytes != 3'd0) begin
                  state_in = ST_TAIL;
               end else if (q_item.last_word) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_K1: begin
            mul_a    = item_ff.data_word;
            k_in     = product;
            state_in = ST_K2;
         end
         ST_K2: begin
            mul_a    = k_ff ^ (k_ff >> MIX_SHIFT);
            k_in     = product;
            state_in = ST_HMIX;
         end
         ST_HMIX: begin
            mul_a    = hash_ff;
            hash_in  = product ^ k_ff;
            state_in = item_ff.last_word ? ST_FIN : ST_IDLE;
         end
         ST_TAIL: begin
            mul_a    = hash_ff ^ (item_ff.data_word & tail_mask);
            hash_in  = product;
            state_in = item_ff.last_word ? ST_FIN : ST_IDLE;
         end
         ST_FIN: begin
            mul_a    = hash_ff ^ (hash_ff >> FIN_SHIFT_A);
            k_in     = product;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_data_in  = k_ff ^ (k_ff >> FIN_SHIFT_B);
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      item_ff     <= item_in;
      hash_ff     <= hash_in;
      k_ff        <= k_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

`ifndef ASSERT_OFF
   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE) && q_valid)
      else $error("queue popped outside idle");

   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside emit step");

   a_k2_after_k1: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_K1) |=> (state_ff == ST_K2))
      else $error("word mix sequence broken");
`endif

endmodule

[rtl/murmurhash2_stream_hasher.sv]
// murmurhash2_stream_hasher: top level, front, queue and hash engine wired together
// depends on mhs_pkg, mhs_front, mhs_fifo, mhs_engine
`timescale 1ns / 1ps

// 32-bit murmurhash2 over a message streamed as little-endian words. the item
// flagged in tuser (first_word) opens a message and starts the hash as the seed
// xor the message length; tlast closes it and one hash result follows on rsp.
// items outside a message are dropped. a front stage classifies items into a
// two-entry queue; the engine behind it shares one 32x32 multiplier, so a full
// word steps through K1, K2 and HMIX, a partial word through TAIL, and the
// closing item then through FIN and EMIT to the output register. the seed on
// csr is taken at any time but should only change between messages.
module murmurhash2_stream_hasher #(
   parameter int MAX_MESSAGE_BYTES = 65535
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // data_word[31:0], valid_bytes[34:32],
                                   // message_length[50:35], zero pad
   input  logic        req_tlast,  // last_word
   input  logic        req_tuser,  // first_word
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // result hash
   // seed register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data    // hash_seed
);
   import mhs_pkg::*;

   logic [31:0] seed_ff;
   logic [31:0] seed_in;
   logic        q_push;
   logic        q_full;
   logic        q_pop;
   logic        q_valid;
   item_type    front_item;
   item_type    queue_item;

   // seed register, always writable
   assign csr_ready = 1'b1;
   assign seed_in   = (csr_valid && csr_ready) ? csr_data : seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
      end else begin
         seed_ff <= seed_in;
      end
   end

   // front: accept and drop items outside a message
   mhs_front #(
      .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (front_item)
   );

   // queue decouples front from engine
   mhs_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_item  (queue_item)
   );

   // engine: mix, finalize, hold the result item
   mhs_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .seed       (seed_ff),
      .q_valid    (q_valid),
      .q_item     (queue_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
